// ===== rtl/preemptive_priority_scheduler_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler
// Concurrent checks with reset gating, used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PPS_ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PPS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("scheduler assertion failed");

`endif

// ===== rtl/pps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, codes and the candidate record passed along the cell chain.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int CFG_W     = 5;
    localparam int TIME_W    = 24;
    localparam int ID_W      = 8;
    localparam int PRI_W     = 8;
    localparam int T16_W     = 16;
    localparam int SLOT_IN_W = 4;
    localparam int CNT_SAT   = 31;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Input item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 120;

    // Best ready entry seen so far while walking the chain
    typedef struct packed {
        logic               found;
        logic [PRI_W-1:0]   prio;
        logic [ID_W-1:0]    id;
        logic [T16_W-1:0]   arrival;
        logic [T16_W-1:0]   burst;
        logic [T16_W-1:0]   remaining;
    } cand_t;

endpackage

// ===== rtl/preemptive_priority_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Preemptive priority scheduler over a row of process-slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_wdata set the number of slots in use (write only while idle).
//   s_* carries one transaction per item: s_tuser selects load (0) or tick (1).
//   A load writes one slot in the cycle it is accepted and gives no result.
//   A tick sends a candidate record down the chain of MAX_PROCS cells, one
//   cell per cycle, during the scan state; the calc state then works out
//   the completion figures and the write state loads the output register.
//   s_tready returns with m_tvalid, so no new item is taken while a tick
//   is still being worked on. Only one item is in flight.
//   m_* carries one result transaction per tick. The output register holds a
//   result while the receiver stalls; the next item is accepted meanwhile,
//   and a following tick waits for the register to free before it finishes.
//   Reset clears tick time, completion count, chart history and the output;
//   the slot tables keep their contents and must be loaded before use.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_core_macros.svh"

module preemptive_priority_scheduler_core
    import pps_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [3:0] slot, [11:4] process_id, [19:12] priority_req,
    // [35:20] arrival_time, [51:36] burst_time, [55:52] zero
    input  logic [S_TDATA_W-1:0]    s_tdata,
    // [0] kind
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [23:0] time_now, [24] cpu_idle, [32:25] running_id, [33] chart_new,
    // [34] finished, [42:35] finished_id, [66:43] completion_time,
    // [90:67] turnaround_time, [114:91] waiting_time, [115] all_done,
    // [119:116] zero
    output logic [M_TDATA_W-1:0]    m_tdata
);

    localparam int SLOT_W = $clog2(MAX_PROCS);
    localparam int NW     = ($clog2(MAX_PROCS + 1) > CFG_W) ? $clog2(MAX_PROCS + 1) : CFG_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    // Control state
    logic [1:0]         state_reg, state_next;
    logic [SLOT_W-1:0]  scan_cnt_reg;
    logic [CFG_W-1:0]   num_reg;
    logic [TIME_W-1:0]  tick_reg;
    logic [CFG_W-1:0]   fin_cnt_reg, fin_cnt_next;
    logic               last_valid_reg;
    logic               m_tvalid_reg;

    // Chart history and result stage payload
    logic               last_idle_reg;
    logic [ID_W-1:0]    last_id_reg;
    logic [TIME_W-1:0]  st_time_reg;
    logic               st_idle_reg;
    logic [ID_W-1:0]    st_run_id_reg;
    logic               st_chart_reg;
    logic               st_fin_reg;
    logic [ID_W-1:0]    st_fin_id_reg;
    logic [TIME_W-1:0]  st_comp_reg;
    logic [TIME_W-1:0]  st_tat_reg;
    logic [T16_W-1:0]   st_burst_reg;
    logic               st_done_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Chain
    cand_t              cand_chain [0:MAX_PROCS];
    logic [SLOT_W-1:0]  slot_chain [0:MAX_PROCS];
    logic [MAX_PROCS-1:0] wr_vec;
    logic [MAX_PROCS-1:0] dec_vec;
    logic [MAX_PROCS-1:0] in_use_vec;

    logic               accept;
    logic               load_fire;
    logic               tick_fire;
    logic               out_free;
    logic [NW-1:0]      n_eff;
    cand_t              win;
    logic [SLOT_W-1:0]  win_slot;
    logic               win_fin;
    logic               chart_new;
    logic [TIME_W-1:0]  comp;
    logic [TIME_W-1:0]  arr_ext;
    logic [TIME_W-1:0]  burst_ext;
    logic [TIME_W-1:0]  wt;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign load_fire = accept && (s_tuser == KIND_LOAD);
    assign tick_fire = accept && (s_tuser == KIND_TICK);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Clamp the process count into 1..MAX_PROCS
    always_comb begin
        if (num_reg == '0) begin
            n_eff = NW'(1);
        end else if (NW'(num_reg) > NW'(MAX_PROCS)) begin
            n_eff = NW'(MAX_PROCS);
        end else begin
            n_eff = NW'(num_reg);
        end
    end

    assign cand_chain[0] = '0;
    assign slot_chain[0] = '0;
    assign win      = cand_chain[MAX_PROCS];
    assign win_slot = slot_chain[MAX_PROCS];
    assign win_fin  = win.found && (win.remaining == T16_W'(1));

    // Row of slot cells
    genvar i;
    generate
        for (i = 0; i < MAX_PROCS; i++) begin : g_cell
            if (i < (1 << SLOT_IN_W)) begin : g_wr
                assign wr_vec[i] = load_fire && (s_tdata[3:0] == SLOT_IN_W'(i));
            end else begin : g_nowr
                assign wr_vec[i] = 1'b0;
            end
            assign dec_vec[i]    = (state_reg == ST_CALC) && win.found
                                   && (win_slot == SLOT_W'(i));
            assign in_use_vec[i] = (NW'(i) < n_eff);

            pps_cell #(
                .SLOT_W (SLOT_W)
            ) u_cell (
                .aclk       (aclk),
                .wr_en      (wr_vec[i]),
                .wr_id      (s_tdata[11:4]),
                .wr_prio    (s_tdata[19:12]),
                .wr_arrival (s_tdata[35:20]),
                .wr_burst   (s_tdata[51:36]),
                .dec_en     (dec_vec[i]),
                .in_use     (in_use_vec[i]),
                .tick       (tick_reg),
                .my_slot    (SLOT_W'(i)),
                .cand_in    (cand_chain[i]),
                .slot_in    (slot_chain[i]),
                .cand_out   (cand_chain[i+1]),
                .slot_out   (slot_chain[i+1])
            );
        end
    endgenerate

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (tick_fire) state_next = ST_SCAN;
            ST_SCAN:  if (scan_cnt_reg == SLOT_W'(MAX_PROCS - 1)) state_next = ST_CALC;
            ST_CALC:  state_next = ST_WRITE;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Completion count saturates
    always_comb begin
        fin_cnt_next = fin_cnt_reg;
        if (win_fin && (fin_cnt_reg != CFG_W'(CNT_SAT))) begin
            fin_cnt_next = fin_cnt_reg + CFG_W'(1);
        end
    end

    // Chart entry is new on the first tick or when idle state or running id changes
    assign chart_new = !last_valid_reg || (last_idle_reg == win.found)
                       || (win.found && (last_id_reg != win.id));

    // Completion time saturating at TIME_MAX, waiting time floored at zero
    assign comp    = (tick_reg < TIME_MAX) ? tick_reg + TIME_W'(1) : TIME_MAX;
    assign arr_ext = {{(TIME_W-T16_W){1'b0}}, win.arrival};
    assign burst_ext = {{(TIME_W-T16_W){1'b0}}, st_burst_reg};
    assign wt      = (st_tat_reg >= burst_ext) ? st_tat_reg - burst_ext : '0;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            num_reg        <= CFG_W'(1);
            tick_reg       <= '0;
            fin_cnt_reg    <= '0;
            last_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                num_reg <= cfg_wdata;
            end
            if (state_reg == ST_SCAN) begin
                scan_cnt_reg <= scan_cnt_reg + SLOT_W'(1);
            end else begin
                scan_cnt_reg <= '0;
            end
            if (state_reg == ST_CALC) begin
                fin_cnt_reg    <= fin_cnt_next;
                last_valid_reg <= 1'b1;
                if (tick_reg < TIME_MAX) begin
                    tick_reg <= tick_reg + TIME_W'(1);
                end
            end
            // Raise on a finished result, drop once taken
            if ((state_reg == ST_WRITE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result stage and output register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CALC) begin
            last_idle_reg <= !win.found;
            last_id_reg   <= win.id;
            st_time_reg   <= tick_reg;
            st_idle_reg   <= !win.found;
            st_run_id_reg <= win.found ? win.id : '0;
            st_chart_reg  <= chart_new;
            st_fin_reg    <= win_fin;
            st_fin_id_reg <= win_fin ? win.id : '0;
            st_comp_reg   <= win_fin ? comp : '0;
            st_tat_reg    <= (win_fin && (comp >= arr_ext)) ? comp - arr_ext : '0;
            st_burst_reg  <= win_fin ? win.burst : '0;
            st_done_reg   <= (NW'(fin_cnt_next) >= n_eff);
        end
        if ((state_reg == ST_WRITE) && out_free) begin
            m_tdata_reg <= {4'b0, st_done_reg, wt, st_tat_reg, st_comp_reg,
                            st_fin_id_reg, st_fin_reg, st_chart_reg,
                            st_run_id_reg, st_idle_reg, st_time_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `PPS_ASSERT_IMPL(a_fin_not_idle, aclk, aresetn, m_tvalid && m_tdata[34], !m_tdata[24])
    `PPS_ASSERT_IMPL(a_one_dec, aclk, aresetn, 1'b1, $onehot0(dec_vec))
    `PPS_ASSERT_NEXT(a_cnt_mono, aclk, aresetn, 1'b1, fin_cnt_reg >= $past(fin_cnt_reg))

endmodule

// ===== rtl/pps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cell
// One process slot: holds its table entry, merges it into the passing
// candidate and hands the result to the next cell every cycle.
// ----------------------------------------------------------------------------
module pps_cell
    import pps_pkg::*;
#(
    parameter int SLOT_W = 4
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ID_W-1:0]     wr_id,
    input  logic [PRI_W-1:0]    wr_prio,
    input  logic [T16_W-1:0]    wr_arrival,
    input  logic [T16_W-1:0]    wr_burst,
    input  logic                dec_en,
    input  logic                in_use,
    input  logic [TIME_W-1:0]   tick,
    input  logic [SLOT_W-1:0]   my_slot,
    input  cand_t               cand_in,
    input  logic [SLOT_W-1:0]   slot_in,
    output cand_t               cand_out,
    output logic [SLOT_W-1:0]   slot_out
);

    logic [ID_W-1:0]    id_reg;
    logic [PRI_W-1:0]   prio_reg;
    logic [T16_W-1:0]   arrival_reg;
    logic [T16_W-1:0]   burst_reg;
    logic [T16_W-1:0]   remaining_reg;
    cand_t              cand_reg;
    logic [SLOT_W-1:0]  slot_reg;

    logic   ready;
    logic   take;
    cand_t  own;

    // Load a slot or consume one unit of service
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_reg        <= wr_id;
            prio_reg      <= wr_prio;
            arrival_reg   <= wr_arrival;
            burst_reg     <= wr_burst;
            remaining_reg <= wr_burst;
        end else if (dec_en) begin
            remaining_reg <= remaining_reg - T16_W'(1);
        end
    end

    // Ready when in use, arrived and not yet done; strict compare keeps lower slot on ties
    always_comb begin
        ready = in_use && ({{(TIME_W-T16_W){1'b0}}, arrival_reg} <= tick)
                && (remaining_reg != '0);
        take  = ready && (!cand_in.found || (prio_reg > cand_in.prio));
        own.found     = 1'b1;
        own.prio      = prio_reg;
        own.id        = id_reg;
        own.arrival   = arrival_reg;
        own.burst     = burst_reg;
        own.remaining = remaining_reg;
    end

    // Pass the better candidate to the neighbor
    always_ff @(posedge aclk) begin
        cand_reg <= take ? own : cand_in;
        slot_reg <= take ? my_slot : slot_in;
    end

    assign cand_out = cand_reg;
    assign slot_out = slot_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for preemptive_priority_scheduler_core. Load and tick
// transactions go in on the s_ stream. A built-in scheduler model predicts
// every tick result, and each m_ transaction is compared field by field in
// order. Stimulus: a short directed part (single process, priority tie,
// preemption with equal ids, zero burst, count limits), then random
// schedules under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench;
    import pps_pkg::*;

    localparam int PROCS         = 16;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int SETTLE_CYCLES = PROCS + 10;

    // Chart entry encoding: valid marker, idle marker, id in the low byte
    localparam logic [9:0] CHART_EMPTY = 10'h000;
    localparam logic [9:0] CHART_VALID = 10'h200;
    localparam logic [9:0] CHART_IDLE  = 10'h100;

    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic              cpu_idle;
        logic [ID_W-1:0]   running_id;
        logic              chart_new;
        logic              finished;
        logic [ID_W-1:0]   finished_id;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic              all_done;
    } sched_result_t;

    // DUT connections, inputs driven from time zero
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Scheduler model state
    logic [ID_W-1:0]   id_tbl  [PROCS];
    logic [PRI_W-1:0]  pri_tbl [PROCS];
    logic [T16_W-1:0]  arr_tbl [PROCS];
    logic [T16_W-1:0]  bst_tbl [PROCS];
    logic [T16_W-1:0]  rem_tbl [PROCS];
    logic [TIME_W-1:0] tick_cnt   = '0;
    logic [CFG_W-1:0]  done_cnt   = '0;
    logic [9:0]        last_entry = CHART_EMPTY;
    logic [CFG_W-1:0]  proc_cfg   = 5'd1;

    sched_result_t expected_ticks[$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int err_cnt       = 0;
    int items_sent    = 0;
    int load_cnt      = 0;
    int tick_cnt_sent = 0;
    int finish_seen   = 0;
    int idle_cycles   = 0;

    preemptive_priority_scheduler_core #(
        .MAX_PROCS (PROCS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Number of slots the schedule actually scans
    function automatic int slots_in_use();
        if (proc_cfg == 0) begin
            return 1;
        end
        if (proc_cfg > PROCS) begin
            return PROCS;
        end
        return int'(proc_cfg);
    endfunction

    // Execute one tick on the model and return what the block should report
    function automatic sched_result_t schedule_tick();
        sched_result_t     r;
        int                sel;
        int                lim;
        logic [PRI_W-1:0]  best;
        logic [9:0]        entry;
        logic [TIME_W-1:0] comp;
        logic [TIME_W-1:0] tat;
        sel  = -1;
        best = '0;
        lim  = slots_in_use();
        r    = '0;
        for (int i = 0; i < lim; i++) begin
            if ({8'd0, arr_tbl[i]} <= tick_cnt && rem_tbl[i] != 0 &&
                (sel < 0 || pri_tbl[i] > best)) begin
                best = pri_tbl[i];
                sel  = i;
            end
        end
        r.time_now = tick_cnt;
        if (sel < 0) begin
            entry      = CHART_VALID | CHART_IDLE;
            r.cpu_idle = 1'b1;
        end else begin
            entry        = CHART_VALID | {2'b00, id_tbl[sel]};
            r.running_id = id_tbl[sel];
            rem_tbl[sel] = rem_tbl[sel] - 1'b1;
            if (rem_tbl[sel] == 0) begin
                comp = (tick_cnt < TIME_MAX) ? tick_cnt + 1'b1 : TIME_MAX;
                tat  = (comp >= {8'd0, arr_tbl[sel]}) ? comp - arr_tbl[sel] : '0;
                r.finished        = 1'b1;
                r.finished_id     = id_tbl[sel];
                r.completion_time = comp;
                r.turnaround_time = tat;
                r.waiting_time    = (tat >= {8'd0, bst_tbl[sel]}) ? tat - bst_tbl[sel] : '0;
                if (done_cnt < CNT_SAT) begin
                    done_cnt = done_cnt + 1'b1;
                end
            end
        end
        r.chart_new = (entry != last_entry);
        last_entry  = entry;
        r.all_done  = (int'(done_cnt) >= lim);
        if (tick_cnt < TIME_MAX) begin
            tick_cnt = tick_cnt + 1'b1;
        end
        return r;
    endfunction

    // Send one transaction; the model follows once it is accepted
    task automatic push_item(input logic knd, input logic [3:0] slot,
                             input logic [7:0] pid, input logic [7:0] pri,
                             input logic [15:0] arr, input logic [15:0] bst);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= knd;
        s_tdata  <= {4'd0, bst, arr, pri, pid, slot};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (knd == KIND_LOAD) begin
            load_cnt++;
            id_tbl[slot]  = pid;
            pri_tbl[slot] = pri;
            arr_tbl[slot] = arr;
            bst_tbl[slot] = bst;
            rem_tbl[slot] = bst;
        end else begin
            tick_cnt_sent++;
            expected_ticks.push_back(schedule_tick());
        end
    endtask

    task automatic load_slot(input logic [3:0] slot, input logic [7:0] pid,
                             input logic [7:0] pri, input logic [15:0] arr,
                             input logic [15:0] bst);
        push_item(KIND_LOAD, slot, pid, pri, arr, bst);
    endtask

    // Unused fields of a tick carry random bits
    task automatic advance_tick();
        push_item(KIND_TICK, 4'($urandom), 8'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    // Drain all results, let the block settle, then write the slot count
    task automatic set_slot_count(input logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        proc_cfg  = val;
    endtask

    // One process at full priority, then idle ticks
    task automatic test_single_process();
        load_slot(4'd0, 8'hFF, 8'hFF, 16'd0, 16'd2);
        repeat (4) advance_tick();
    endtask

    // Tie on priority, zero burst, preemption by a reload with the same id
    task automatic test_tie_and_preemption();
        logic [15:0] t0;
        set_slot_count(5'd3);
        t0 = 16'(tick_cnt);
        load_slot(4'd0, 8'd1, 8'd100, t0, 16'd3);
        load_slot(4'd1, 8'd2, 8'd100, t0, 16'd1);
        load_slot(4'd2, 8'd3, 8'd255, 16'd0, 16'd0);
        load_slot(4'd3, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF);
        advance_tick();
        load_slot(4'd1, 8'd1, 8'd200, t0 + 16'd1, 16'd2);
        repeat (6) advance_tick();
    endtask

    // Random process content: mostly near-term arrivals and short bursts
    task automatic load_random(input logic [3:0] slot, inout int work);
        logic [7:0]  pid;
        logic [15:0] arr;
        logic [15:0] bst;
        int          nominal;
        pid     = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
        nominal = int'(tick_cnt) + $urandom_range(8);
        arr     = (nominal > 65535) ? 16'hFFFF : 16'(nominal);
        bst     = 16'($urandom_range(1, 6));
        if ($urandom_range(15) == 0) begin
            arr = 16'($urandom);
        end
        case ($urandom_range(31))
            0: bst = 16'($urandom_range(1, 65535));
            1: bst = 16'd0;
            default: work += int'(bst);
        endcase
        load_slot(slot, pid, 8'($urandom), arr, bst);
    endtask

    // Whole schedules: load every slot in use, then tick with reloads mixed in
    task automatic test_random_schedules(input int src_pct, input int snk_pct,
                                         input int n_items);
        int          target;
        int          sched_idx;
        int          lim;
        int          work;
        int          ticks;
        logic [4:0]  cfg_val;
        target        = items_sent + n_items;
        sched_idx     = 0;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        while (items_sent < target) begin
            case (sched_idx)
                0: cfg_val = 5'd16;
                1: cfg_val = 5'd0;
                2: cfg_val = 5'd31;
                default: begin
                    case ($urandom_range(9))
                        0: cfg_val = 5'd1;
                        1: cfg_val = 5'd16;
                        2: cfg_val = 5'd0;
                        3: cfg_val = 5'($urandom_range(17, 31));
                        default: cfg_val = 5'($urandom_range(1, 8));
                    endcase
                end
            endcase
            sched_idx++;
            set_slot_count(cfg_val);
            lim  = slots_in_use();
            work = 0;
            for (int s = 0; s < lim; s++) begin
                load_random(4'(s), work);
            end
            ticks = (work + 12 > 100) ? 100 : work + 12;
            for (int t = 0; t < ticks; t++) begin
                // preempt with a fresh arrival in a slot in use
                if ($urandom_range(11) == 0) begin
                    load_random(4'($urandom_range(lim - 1)), work);
                end
                // stray load anywhere in the table
                if ($urandom_range(19) == 0) begin
                    load_slot(4'($urandom), 8'($urandom), 8'($urandom),
                              16'($urandom), 16'($urandom));
                end
                advance_tick();
            end
        end
    endtask

    // Randomly stall the result channel
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.time_now        = m_tdata[23:0];
            got.cpu_idle        = m_tdata[24];
            got.running_id      = m_tdata[32:25];
            got.chart_new       = m_tdata[33];
            got.finished        = m_tdata[34];
            got.finished_id     = m_tdata[42:35];
            got.completion_time = m_tdata[66:43];
            got.turnaround_time = m_tdata[90:67];
            got.waiting_time    = m_tdata[114:91];
            got.all_done        = m_tdata[115];
            if (expected_ticks.size() == 0) begin
                $error("result transaction with no tick outstanding: %h", m_tdata);
                err_cnt++;
            end else begin
                exp_r = expected_ticks.pop_front();
                if (got.finished) begin
                    finish_seen++;
                end
                if (got !== exp_r) begin
                    err_cnt++;
                    if (got.time_now !== exp_r.time_now)
                        $error("time_now: expected %0d, got %0d", exp_r.time_now, got.time_now);
                    if (got.cpu_idle !== exp_r.cpu_idle)
                        $error("cpu_idle: expected %0d, got %0d", exp_r.cpu_idle, got.cpu_idle);
                    if (got.running_id !== exp_r.running_id)
                        $error("running_id: expected %0d, got %0d",
                               exp_r.running_id, got.running_id);
                    if (got.chart_new !== exp_r.chart_new)
                        $error("chart_new: expected %0d, got %0d", exp_r.chart_new, got.chart_new);
                    if (got.finished !== exp_r.finished)
                        $error("finished: expected %0d, got %0d", exp_r.finished, got.finished);
                    if (got.finished_id !== exp_r.finished_id)
                        $error("finished_id: expected %0d, got %0d",
                               exp_r.finished_id, got.finished_id);
                    if (got.completion_time !== exp_r.completion_time)
                        $error("completion_time: expected %0d, got %0d",
                               exp_r.completion_time, got.completion_time);
                    if (got.turnaround_time !== exp_r.turnaround_time)
                        $error("turnaround_time: expected %0d, got %0d",
                               exp_r.turnaround_time, got.turnaround_time);
                    if (got.waiting_time !== exp_r.waiting_time)
                        $error("waiting_time: expected %0d, got %0d",
                               exp_r.waiting_time, got.waiting_time);
                    if (got.all_done !== exp_r.all_done)
                        $error("all_done: expected %0d, got %0d", exp_r.all_done, got.all_done);
                end
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
            $display("FAIL preemptive_priority_scheduler_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_process();
        test_tie_and_preemption();
        test_random_schedules(14, 64, 620);
        test_random_schedules(64, 14, 610);
        test_random_schedules(0, 0, 610);

        // wait for the last results, then let the block go quiet
        s_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d loads and %0d ticks over slot counts 0..31, three idling mixes",
                 load_cnt, tick_cnt_sent);
        $display("Checked %0d completions, final tick %0d, %0d mismatching results",
                 finish_seen, tick_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("PASS preemptive_priority_scheduler_core");
        end else begin
            $display("FAIL preemptive_priority_scheduler_core");
        end
        $finish;
    end

endmodule
